@@ hdl/amd_pkg.sv @@
// shared types and constants for the addressed message deframer
package amd_pkg;

  localparam int ByteW = 8;
  localparam int KindW = 2;
  localparam int CfgIdxW = 8;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_START_MARKER    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_OWN_ADDRESS     = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_SUB_ADDRESS = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_PING_COMMAND    = 8'd3;

  // register reset values
  localparam logic [ByteW-1:0] RST_START_MARKER    = 8'd77;
  localparam logic [ByteW-1:0] RST_OWN_ADDRESS     = 8'd1;
  localparam logic [ByteW-1:0] RST_MAX_SUB_ADDRESS = 8'd255;
  localparam logic [ByteW-1:0] RST_PING_COMMAND    = 8'd128;

  localparam logic [ByteW-1:0] SYSTEM_ADDRESS = 8'h00;
  localparam logic [ByteW-1:0] ONE_BYTE       = 8'h01;

  // result kinds
  localparam logic [KindW-1:0] KIND_SYSTEM = 2'd0;
  localparam logic [KindW-1:0] KIND_DEVICE = 2'd1;
  localparam logic [KindW-1:0] KIND_PING   = 2'd2;

  typedef enum logic [2:0] {
    POS_HUNT = 3'd0,
    POS_ADDR = 3'd1,
    POS_SUB  = 3'd2,
    POS_SIZE = 3'd3,
    POS_CMD  = 3'd4,
    POS_DATA = 3'd5,
    POS_PING = 3'd6
  } pos_t;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] own_address;
    logic [ByteW-1:0] max_sub_address;
    logic [ByteW-1:0] ping_command;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] sub_address;
    logic [ByteW-1:0] command;
    logic             is_command;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] body_index;
    logic             last;
  } result_t;

endpackage

@@ hdl/amd_if.sv @@
// channel interfaces: received bytes, parsed results, configuration writes
interface amd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface amd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] sub_address;
  logic [7:0] command;
  logic       is_command;
  logic [7:0] data_byte;
  logic [7:0] body_index;
  logic       last;
  modport source (output valid, output kind, output sub_address, output command,
                  output is_command, output data_byte, output body_index,
                  output last, input ready);
  modport sink (input valid, input kind, input sub_address, input command,
                input is_command, input data_byte, input body_index,
                input last, output ready);
endinterface

interface amd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/amd_in_stage.sv @@
// input register holding one received byte
module amd_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  amd_byte_if.sink                  rx,
  input  logic                      advance,
  output logic                      held_valid,
  output logic [amd_pkg::ByteW-1:0] held_byte
);
  import amd_pkg::*;

  assign rx.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

@@ hdl/amd_parser.sv @@
// frame parser state machine, one byte per step
module amd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  amd_pkg::cfg_t             cfg,
  input  logic                      step,
  input  logic [amd_pkg::ByteW-1:0] byte_in,
  output logic                      emit,
  output amd_pkg::result_t          result
);
  import amd_pkg::*;

  pos_t             position, position_next;
  logic             system_frame, system_frame_next;
  logic [ByteW-1:0] held_sub_address, held_sub_address_next;
  logic [ByteW-1:0] body_size, body_size_next;
  logic [ByteW-1:0] body_count, body_count_next;
  logic [ByteW-1:0] held_command, held_command_next;
  logic [ByteW-1:0] count_inc;
  logic             body_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= POS_HUNT;
      system_frame     <= 1'b0;
      held_sub_address <= '0;
      body_size        <= '0;
      body_count       <= '0;
      held_command     <= '0;
    end else if (step) begin
      position         <= position_next;
      system_frame     <= system_frame_next;
      held_sub_address <= held_sub_address_next;
      body_size        <= body_size_next;
      body_count       <= body_count_next;
      held_command     <= held_command_next;
    end
  end

  assign count_inc = body_count + ONE_BYTE;

  always_comb begin
    position_next         = position;
    system_frame_next     = system_frame;
    held_sub_address_next = held_sub_address;
    body_size_next        = body_size;
    body_count_next       = body_count;
    held_command_next     = held_command;
    body_last             = 1'b0;
    emit                  = 1'b0;
    result.kind           = system_frame ? KIND_SYSTEM : KIND_DEVICE;
    result.is_command     = 1'b0;
    result.data_byte      = byte_in;
    result.body_index     = '0;
    result.last           = 1'b0;
    case (position)
      POS_ADDR: begin
        if (byte_in == SYSTEM_ADDRESS) begin
          system_frame_next = 1'b1;
          position_next     = POS_SUB;
        end else if (byte_in == cfg.own_address) begin
          system_frame_next = 1'b0;
          position_next     = POS_SUB;
        end else begin
          position_next = POS_HUNT;
        end
      end
      POS_SUB: begin
        if (byte_in <= cfg.max_sub_address) begin
          held_sub_address_next = byte_in;
          position_next         = POS_SIZE;
        end else begin
          position_next = POS_HUNT;
        end
      end
      POS_SIZE: begin
        body_size_next  = byte_in;
        body_count_next = '0;
        position_next   = (byte_in == '0) ? POS_HUNT : POS_CMD;
      end
      POS_CMD: begin
        held_command_next = byte_in;
        body_count_next   = ONE_BYTE;
        body_last         = (body_size == ONE_BYTE);
        if (system_frame && byte_in == cfg.ping_command) begin
          // ping frame: swallow the body, one request at its end
          if (body_last) begin
            position_next    = POS_HUNT;
            emit             = 1'b1;
            result.kind      = KIND_PING;
            result.data_byte = '0;
            result.last      = 1'b1;
          end else begin
            position_next = POS_PING;
          end
        end else begin
          position_next     = body_last ? POS_HUNT : POS_DATA;
          emit              = 1'b1;
          result.is_command = 1'b1;
          result.last       = body_last;
        end
      end
      POS_DATA, POS_PING: begin
        body_last       = (count_inc == body_size);
        body_count_next = count_inc;
        if (body_last) begin
          position_next = POS_HUNT;
        end
        result.body_index = body_count;
        result.last       = body_last;
        if (position == POS_PING) begin
          emit             = body_last;
          result.kind      = KIND_PING;
          result.data_byte = '0;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        position_next = (byte_in == cfg.start_marker) ? POS_ADDR : POS_HUNT;
      end
    endcase
    result.sub_address = held_sub_address_next;
    result.command     = held_command_next;
  end

  // a zero-size body always drops back to the hunt
  a_zero_size_drops: assert property (@(posedge clk) disable iff (rst)
    (step && position == POS_SIZE && byte_in == '0) |=> position == POS_HUNT)
    else $error("zero-size body did not restart the hunt");

  // ping requests close the frame and carry no command byte
  a_ping_shape: assert property (@(posedge clk) disable iff (rst)
    (emit && result.kind == KIND_PING) |-> (result.last && !result.is_command))
    else $error("malformed ping request");

  // the command byte is always body index zero
  a_cmd_index: assert property (@(posedge clk) disable iff (rst)
    (emit && result.is_command) |-> result.body_index == '0)
    else $error("command byte not at index zero");

  // payload states are only reached through the command byte
  a_payload_entry: assert property (@(posedge clk) disable iff (rst)
    (step && (position_next == POS_DATA || position_next == POS_PING)
      && position != POS_DATA && position != POS_PING) |-> position == POS_CMD)
    else $error("payload entered without a command byte");

endmodule

@@ hdl/amd_out_stage.sv @@
// result register between the parser and the result channel
module amd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  amd_pkg::result_t result,
  output logic             free,
  amd_result_if.source     res
);
  import amd_pkg::*;

  result_t held;

  assign free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (free) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= result;
    end
  end

  assign res.kind        = held.kind;
  assign res.sub_address = held.sub_address;
  assign res.command     = held.command;
  assign res.is_command  = held.is_command;
  assign res.data_byte   = held.data_byte;
  assign res.body_index  = held.body_index;
  assign res.last        = held.last;

endmodule

@@ hdl/addressed_message_deframer.sv @@
// top level of the addressed message deframer
//
// rx carries one received serial byte per item. frames are: start marker,
// device address (zero for system or own_address), sub address (at most
// max_sub_address), body size, then the body: command byte and payload.
// res carries one item per body byte, tagged with kind, sub address,
// command and index, last marked on the final byte. a system frame whose
// command is ping_command gives only one ping request item at its end.
// frames failing a check, and zero-size bodies, are dropped silently.
// cfg writes one of four registers by index; indexes beyond three are
// ignored. it is always ready and should only be used while idle.
// a result passes through the input register, then the result register.
// throughput: one byte per cycle while res does not stall, set
// by the single parser step between the two registers.
// reset clears the parser to hunting and loads the register defaults.
// when res stalls, the result register holds and the input register
// fills, then rx ready drops until the result is taken.
module addressed_message_deframer (
  input  logic      clk,
  input  logic      rst,
  amd_byte_if.sink  rx,
  amd_result_if.source res,
  amd_cfg_if.sink   cfg
);
  import amd_pkg::*;

  cfg_t             cfg_regs;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             out_free;
  logic             advance;
  logic             emit;
  result_t          result;

  // configuration registers, written any cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_marker    <= RST_START_MARKER;
      cfg_regs.own_address     <= RST_OWN_ADDRESS;
      cfg_regs.max_sub_address <= RST_MAX_SUB_ADDRESS;
      cfg_regs.ping_command    <= RST_PING_COMMAND;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_MARKER:    cfg_regs.start_marker    <= cfg.data;
        REG_OWN_ADDRESS:     cfg_regs.own_address     <= cfg.data;
        REG_MAX_SUB_ADDRESS: cfg_regs.max_sub_address <= cfg.data;
        REG_PING_COMMAND:    cfg_regs.ping_command    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // a held byte is parsed once the result register can take its result
  assign advance = held_valid && out_free;

  amd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  amd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .step    (advance),
    .byte_in (held_byte),
    .emit    (emit),
    .result  (result)
  );

  amd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .result (result),
    .free   (out_free),
    .res    (res)
  );

endmodule
